/* sv/sha256_pkg.sv */
// SHA-256 hasher package: payload structs, sequencer states, round constants.
// No dependencies.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;
    localparam int unsigned BLOCK_BYTES = 64;

endpackage

/* sv/sha256_byte_stream_hasher_unit.sv */
// SHA-256 byte stream hasher, top level.
// Depends on sha256_pkg and sha256_round.
//
// Usage:
//   s_ channel takes one item: a message byte (if byte_present) and/or an
//   end-of-message mark. m_ channel returns the digest as eight 32-bit items,
//   word_index 0..7, last_word on the eighth.
// Sequence:
//   A byte that does not fill the block is written to the block memory and
//   the block stays idle. A byte that fills the block starts a compression:
//   load, round and fold, done by the single shared round unit doing one
//   round per clock. An end marker costs one or two such compressions plus the
//   pad fill (one byte a cycle into the block memory) and then eight output items.
//   s_ready is low while a block is padded or compressed or the digest drains.
// Reset (aresetn low, synchronous): chain words to the initial hash, byte
//   count and fill to zero, sequencer idle. The buffer is not cleared.
// Stall: when m_ready is low the current digest word holds; the block
//   waits in the emit state until all eight words are taken, then returns
//   to its reset values for the next message.
module sha256_byte_stream_hasher_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sha256_pkg::sha_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sha256_pkg::sha_out_t m_data
);
    import sha256_pkg::*;

    sha_state_t  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_rnd [8];
    logic [31:0] w_rnd [16];
    logic [63:0] count_reg;
    logic [5:0]  fill_reg;
    logic [6:0]  step_reg;      // load/round/emit counter
    logic        final_reg;     // end marker seen: padding in progress
    logic        len_done_reg;  // pad block with length field is the one in flight
    logic        pad_mark_reg;  // 0x80 byte not yet written
    logic [7:0]  mem [64];
    logic [7:0]  rd_byte_reg;

    sha256_round u_round (
        .v_in(v_reg), .w_in(w_reg), .round_idx(step_reg[5:0]),
        .v_out(v_rnd), .w_out(w_rnd)
    );

    logic        acc;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [63:0] bits;
    logic [5:0]  rd_addr;

    assign acc  = s_valid && s_ready;
    assign bits = {count_reg[60:0], 3'b000};

    // write port: message byte in idle, or pad byte for position fill_reg during the pad sweep
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = s_data.data_byte;
        if (state_reg == ST_IDLE && acc && s_data.byte_present) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_PAD) begin
            wr_en = 1'b1;
            if (fill_reg >= 6'(LEN_POS) && len_done_reg) begin
                wr_data = bits[6'(63 - 8 * (fill_reg - 6'(LEN_POS))) -: 8];
            end else if (pad_mark_reg) begin
                wr_data = PAD_BYTE;
            end else begin
                wr_data = 8'h00;
            end
        end
    end

    // read address: load reads bytes step 0..63 one ahead of the shift
    assign rd_addr = step_reg[5:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_byte_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_data.byte_present && fill_reg == 6'd63) begin
                        state_next = ST_LOAD;
                    end else if (s_data.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:  if (step_reg == 7'd64) state_next = ST_ROUND;
            ST_ROUND: if (step_reg == 7'd63) state_next = ST_FOLD;
            ST_FOLD: begin
                if (!final_reg) state_next = ST_IDLE;
                else if (len_done_reg) state_next = ST_EMIT;
                else state_next = ST_PAD;
            end
            ST_PAD:   if (fill_reg == 6'd63) state_next = ST_LOAD;
            ST_EMIT:  if (m_ready && step_reg[2:0] == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready            = (state_reg == ST_IDLE);
        m_valid            = (state_reg == ST_EMIT);
        m_data.digest_word = h_reg[step_reg[2:0]];
        m_data.word_index  = step_reg[2:0];
        m_data.last_word   = (step_reg[2:0] == 3'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            h_reg        <= INIT_H;
            count_reg    <= '0;
            fill_reg     <= '0;
            step_reg     <= '0;
            final_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            pad_mark_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (acc) begin
                        if (s_data.byte_present) begin
                            count_reg <= count_reg + 64'd1;
                            fill_reg  <= fill_reg + 6'd1;
                        end
                        if (s_data.end_of_message) begin
                            final_reg    <= 1'b1;
                            // pad sweep starts at the post-byte fill; a byte that
                            // fills the block pushes the 0x80 into a fresh block
                            pad_mark_reg <= 1'b1;
                            len_done_reg <= ((s_data.byte_present ? fill_reg + 6'd1 :
                                             fill_reg) < 6'(LEN_POS)) &&
                                            !(s_data.byte_present && fill_reg == 6'd63);
                        end
                    end
                end
                ST_PAD: begin
                    step_reg     <= '0;
                    fill_reg     <= fill_reg + 6'd1;
                    pad_mark_reg <= 1'b0;
                end
                ST_LOAD: begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg != 7'd0) begin
                        // each byte enters the newest word; at a word start the
                        // finished word moves down, so word 0 ends in w_reg[0]
                        w_reg[15] <= {w_reg[15][23:0], rd_byte_reg};
                        if (step_reg[1:0] == 2'd1 && step_reg != 7'd1) begin
                            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                        end
                    end
                    if (step_reg == 7'd64) begin
                        step_reg <= '0;
                        v_reg    <= h_reg;
                    end
                end
                ST_ROUND: begin
                    v_reg    <= v_rnd;
                    w_reg    <= w_rnd;
                    step_reg <= step_reg + 7'd1;
                end
                ST_FOLD: begin
                    step_reg <= final_reg ? 7'd0 : 7'd0;
                    if (final_reg && len_done_reg) begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    end else begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                        len_done_reg <= final_reg;
                    end
                    fill_reg <= '0;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        step_reg <= step_reg + 7'd1;
                        if (step_reg[2:0] == 3'd7) begin
                            h_reg        <= INIT_H;
                            count_reg    <= '0;
                            fill_reg     <= '0;
                            step_reg     <= '0;
                            final_reg    <= 1'b0;
                            len_done_reg <= 1'b0;
                            pad_mark_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* sv/sha256_round.sv */
// One SHA-256 round plus one message schedule step, shared over all 64 rounds.
// Depends on sha256_pkg.
module sha256_round (
    input  logic [31:0] v_in  [8],
    input  logic [31:0] w_in  [16],
    input  logic [5:0]  round_idx,
    output logic [31:0] v_out [8],
    output logic [31:0] w_out [16]
);
    import sha256_pkg::*;

    logic [31:0] a, e, t1, t2, s0, s1, x, y;

    always_comb begin
        a  = v_in[0];
        e  = v_in[4];
        t1 = v_in[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & v_in[5]) ^ (~e & v_in[6])) + ROUND_K[round_idx] + w_in[0];
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & v_in[1]) ^ (a & v_in[2]) ^ (v_in[1] & v_in[2]));
        v_out[0] = t1 + t2;
        v_out[1] = v_in[0];
        v_out[2] = v_in[1];
        v_out[3] = v_in[2];
        v_out[4] = v_in[3] + t1;
        v_out[5] = v_in[4];
        v_out[6] = v_in[5];
        v_out[7] = v_in[6];
        // rolling 16-word schedule window: w_in[0] is this round's word
        x  = w_in[1];
        y  = w_in[14];
        s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
        s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
        for (int i = 0; i < 15; i++) begin
            w_out[i] = w_in[i+1];
        end
        w_out[15] = s1 + w_in[9] + s0 + w_in[0];
    end
endmodule
